[rtl/core/central_gravity_euler_step_core_assert.svh]
// Assertion helpers for the checker file cges_chk.sv.
`ifndef CENTRAL_GRAVITY_EULER_STEP_CORE_ASSERT_SVH
`define CENTRAL_GRAVITY_EULER_STEP_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define CGES_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cges: check failed");

// Next-cycle implication, masked while reset is high.
`define CGES_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cges: check failed");

// Same-cycle implication that also holds through reset.
`define CGES_ASSERT_RESET(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("cges: check failed");

`endif

[rtl/core/cges_pkg.sv]
package cges_pkg;

  localparam int GM_W      = 50;
  localparam int DT_W      = 21;
  localparam int DT_FRAC   = 20;
  localparam int MUL_DIGIT = 16;
  localparam int CFG_IDX_W = 1;
  localparam int STATUS_W  = 2;

  localparam logic [GM_W-1:0] GM_RESET = 50'd398665900000000;
  localparam logic [DT_W-1:0] DT_RESET = 21'd10486;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam cfg_idx_t REG_GM = 1'b0;
  localparam cfg_idx_t REG_DT = 1'b1;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_ZERO = 2'd1;
  localparam status_t ST_SAT  = 2'd2;

endpackage

[rtl/core/cges_mul.sv]
// Multiplier that takes one MUL_DIGIT-bit digit of b per stage.
module cges_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  localparam int DG = cges_pkg::MUL_DIGIT;
  localparam int NS = (BW + DG - 1) / DG;
  localparam int BP = NS * DG;
  localparam int PW = AW + BP;

  logic [AW-1:0] a_q [NS];
  logic [BP-1:0] b_q [NS];
  logic [PW-1:0] p_q [NS];
  logic [BP-1:0] b_pad;

  assign b_pad = BP'(b);

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [AW+DG-1:0] pp;
    if (k == 0) begin : g_first
      assign pp = (AW+DG)'(a) * (AW+DG)'(b_pad[DG-1:0]);
      always_ff @(posedge clk) begin
        if (en) begin
          a_q[0] <= a;
          b_q[0] <= b_pad;
          p_q[0] <= PW'(pp);
        end
      end
    end else begin : g_next
      assign pp = (AW+DG)'(a_q[k-1]) * (AW+DG)'(b_q[k-1][k*DG +: DG]);
      always_ff @(posedge clk) begin
        if (en) begin
          a_q[k] <= a_q[k-1];
          b_q[k] <= b_q[k-1];
          p_q[k] <= p_q[k-1] + (PW'(pp) << (k * DG));
        end
      end
    end
  end

  assign p = p_q[NS-1][AW+BW-1:0];

endmodule

[rtl/core/cges_div.sv]
// Restoring divider, one quotient bit per stage. ovf flags a quotient
// that does not fit in QW bits; q is then meaningless.
module cges_div #(
  parameter int NW = 147,
  parameter int DW = 147,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic          ovf
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] n_q   [QW+1];
  logic [DW-1:0] d_q   [QW+1];
  logic          ovf_q [QW+1];

  logic [CW-1:0] num_x;
  logic [CW-1:0] den_sh;

  assign num_x  = CW'(num);
  assign den_sh = CW'({den, {QW{1'b0}}});

  // Upper numerator bits give no quotient bits when there is no overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= num_x[QW +: DW];
      n_q[0]   <= num[QW-1:0];
      d_q[0]   <= den;
      ovf_q[0] <= (num_x >= den_sh);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;
    assign r2   = {rem_q[k-1], n_q[k-1][QW-1]};
    assign ge   = (r2 >= {1'b0, d_q[k-1]});
    assign diff = r2 - {1'b0, d_q[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
        n_q[k]   <= {n_q[k-1][QW-2:0], ge};
        d_q[k]   <= d_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q   = n_q[QW];
  assign ovf = ovf_q[QW];

endmodule

[rtl/core/cges_dly.sv]
// Fixed-length delay line that advances with the pipeline.
module cges_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

[rtl/core/central_gravity_euler_step_core.sv]
// Explicit Euler step of one body around a central mass at the origin.
// Each item carries position and velocity (signed, FRAC_BITS fraction);
// the result is the advanced position and velocity, saturated, with a
// status in tuser (ok, zero radius, saturated). The block is one pipeline
// that accepts an item every cycle, built on the bit-per-stage square root
// and the bit-per-stage divider that forms GM*p*dt / (r^2*r). When the
// output item is not taken, the whole pipeline holds and s_axis_tready
// drops.
// gm_value and time_step are read live; change them only while idle.
module central_gravity_euler_step_core #(
  parameter int WORD_WIDTH = 48,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from bit 0 up, zero padded
  input  logic [((6*WORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, zero padded
  output logic [((6*WORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [cges_pkg::STATUS_W-1:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [cges_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cges_pkg::GM_W-1:0] cfg_data
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DG    = cges_pkg::MUL_DIGIT;
  localparam int GMW   = cges_pkg::GM_W;
  localparam int DTW   = cges_pkg::DT_W;
  localparam int DTF   = cges_pkg::DT_FRAC;
  localparam int OUT_W = ((6*W+7)/8)*8;
  localparam int SW    = 2*W + 2;
  localparam int RW    = W + 1;
  localparam int DENW  = SW + RW;
  localparam int GPW   = GMW + W;
  localparam int NPW   = GPW + DTW;
  localparam int SHL   = 3*F - DTF;
  localparam int NW    = NPW + SHL;
  localparam int VPW   = W + DTW;

  // stage ages: data held in the input register is age 1
  localparam int LM_SQ  = (W + DG - 1) / DG;
  localparam int LM_DEN = (RW + DG - 1) / DG;
  localparam int LM_GM  = (W + DG - 1) / DG;
  localparam int LM_DT  = (DTW + DG - 1) / DG;
  localparam int AS     = LM_SQ + 2;
  localparam int AR     = AS + RW;
  localparam int AD     = AR + LM_DEN;
  localparam int AN     = 1 + LM_GM + LM_DT;
  localparam int AV     = 1 + LM_DT;
  localparam int AQ     = AD + W + 1;

  logic [GMW-1:0] gm_value;
  logic [DTW-1:0] time_step;
  logic           en;
  logic [AQ:0]    vld;
  logic [6*W-1:0] in_q;

  assign en            = !vld[AQ] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[AQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      gm_value  <= cges_pkg::GM_RESET;
      time_step <= cges_pkg::DT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cges_pkg::REG_GM: gm_value  <= cfg_data;
        cges_pkg::REG_DT: time_step <= cfg_data[DTW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[AQ-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_q <= s_axis_tdata[6*W-1:0];
    end
  end

  // front end: magnitudes and per-axis products
  logic [2*W-1:0] sq   [3];
  logic [NPW-1:0] nprod[3];
  logic [VPW-1:0] vprod[3];

  for (genvar k = 0; k < 3; k++) begin : g_axis_in
    logic [W-1:0]   p_raw;
    logic [W-1:0]   v_raw;
    logic [W-1:0]   pmag;
    logic [W-1:0]   vmag;
    logic [GPW-1:0] gprod;
    assign p_raw = in_q[k*W +: W];
    assign v_raw = in_q[(k+3)*W +: W];
    assign pmag  = p_raw[W-1] ? (~p_raw + 1'b1) : p_raw;
    assign vmag  = v_raw[W-1] ? (~v_raw + 1'b1) : v_raw;

    cges_mul #(.AW(W), .BW(W)) u_sq (
      .clk(clk), .en(en), .a(pmag), .b(pmag), .p(sq[k])
    );
    cges_mul #(.AW(GMW), .BW(W)) u_gm (
      .clk(clk), .en(en), .a(gm_value), .b(pmag), .p(gprod)
    );
    cges_mul #(.AW(GPW), .BW(DTW)) u_gdt (
      .clk(clk), .en(en), .a(gprod), .b(time_step), .p(nprod[k])
    );
    cges_mul #(.AW(W), .BW(DTW)) u_vdt (
      .clk(clk), .en(en), .a(vmag), .b(time_step), .p(vprod[k])
    );
  end

  logic [SW-1:0] s_q;

  always_ff @(posedge clk) begin
    if (en) begin
      s_q <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    end
  end

  // integer square root, one result bit per stage
  logic [RW:0]   rt_rem  [RW];
  logic [RW-1:0] rt_root [RW];
  logic [SW-1:0] rt_rest [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [RW:0]   rem_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] rest_in;
    logic [RW+2:0] rem2;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = s_q;
    end else begin : g_next
      assign rem_in  = rt_rem[j-1];
      assign root_in = rt_root[j-1];
      assign rest_in = rt_rest[j-1];
    end
    assign rem2  = {rem_in, rest_in[SW-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (rem2 >= trial);
    assign diff  = rem2 - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rt_rem[j]  <= ge ? diff[RW:0] : rem2[RW:0];
        rt_root[j] <= {root_in[RW-2:0], ge};
        rt_rest[j] <= {rest_in[SW-3:0], 2'b00};
      end
    end
  end

  logic [SW-1:0]   s_dly;
  logic [DENW-1:0] den;

  cges_dly #(.WIDTH(SW), .DEPTH(RW)) u_s_dly (
    .clk(clk), .en(en), .d(s_q), .q(s_dly)
  );

  cges_mul #(.AW(SW), .BW(RW)) u_den (
    .clk(clk), .en(en), .a(s_dly), .b(rt_root[RW-1]), .p(den)
  );

  // per-axis division and aligned side data
  logic [W-1:0]   qv   [3];
  logic           qovf [3];
  logic [VPW-1:0] vp_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis_div
    logic [NPW-1:0] np_d;
    cges_dly #(.WIDTH(NPW), .DEPTH(AD - AN)) u_np_dly (
      .clk(clk), .en(en), .d(nprod[k]), .q(np_d)
    );
    cges_div #(.NW(NW), .DW(DENW), .QW(W)) u_div (
      .clk(clk), .en(en), .num({np_d, {SHL{1'b0}}}), .den(den),
      .q(qv[k]), .ovf(qovf[k])
    );
    cges_dly #(.WIDTH(VPW), .DEPTH(AQ - AV)) u_vp_dly (
      .clk(clk), .en(en), .d(vprod[k]), .q(vp_d[k])
    );
  end

  logic [6*W-1:0] side;
  logic           zero;

  cges_dly #(.WIDTH(6*W), .DEPTH(AQ - 1)) u_side_dly (
    .clk(clk), .en(en), .d(in_q), .q(side)
  );
  cges_dly #(.WIDTH(1), .DEPTH(AQ - AS)) u_zero_dly (
    .clk(clk), .en(en), .d(s_q == '0), .q(zero)
  );

  // final adds with clamping
  localparam logic signed [W+2:0] SMAX = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] SMIN = {4'b1111, {(W-1){1'b0}}};

  logic [6*W-1:0]     res;
  logic               sat_any;
  cges_pkg::status_t  status;

  always_comb begin
    logic signed [W+2:0] pos_s;
    logic signed [W+2:0] vel_s;
    logic signed [W+2:0] psum;
    logic signed [W+2:0] vsum;
    logic [W+2:0]        dp_e;
    logic [W+2:0]        dv_e;
    logic                pneg;
    logic                vneg;
    res     = '0;
    sat_any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      pneg  = side[k*W + W - 1];
      vneg  = side[(k+3)*W + W - 1];
      pos_s = {{3{pneg}}, side[k*W +: W]};
      vel_s = {{3{vneg}}, side[(k+3)*W +: W]};
      dp_e  = {2'b00, vp_d[k][DTF +: W+1]};
      dv_e  = zero ? '0 : {3'b000, qv[k]};
      psum  = vneg ? (pos_s - dp_e) : (pos_s + dp_e);
      vsum  = pneg ? (vel_s + dv_e) : (vel_s - dv_e);
      if (psum > SMAX) begin
        res[k*W +: W] = SMAX[W-1:0];
        sat_any = 1'b1;
      end else if (psum < SMIN) begin
        res[k*W +: W] = SMIN[W-1:0];
        sat_any = 1'b1;
      end else begin
        res[k*W +: W] = psum[W-1:0];
      end
      // a quotient past the word always drives the sum off the end
      if (!zero && qovf[k]) begin
        res[(k+3)*W +: W] = pneg ? SMAX[W-1:0] : SMIN[W-1:0];
        sat_any = 1'b1;
      end else if (vsum > SMAX) begin
        res[(k+3)*W +: W] = SMAX[W-1:0];
        sat_any = 1'b1;
      end else if (vsum < SMIN) begin
        res[(k+3)*W +: W] = SMIN[W-1:0];
        sat_any = 1'b1;
      end else begin
        res[(k+3)*W +: W] = vsum[W-1:0];
      end
    end
    if (sat_any) begin
      status = cges_pkg::ST_SAT;
    end else if (zero) begin
      status = cges_pkg::ST_ZERO;
    end else begin
      status = cges_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_W'(res);
      m_axis_tuser <= status;
    end
  end

endmodule

[rtl/core/cges_chk.sv]
`include "central_gravity_euler_step_core_assert.svh"

module cges_chk #(
  parameter int DATA_W = 288
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [cges_pkg::STATUS_W-1:0] m_axis_tuser
);

  // a stalled result item stays put
  `CGES_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // input side stalls exactly when a result waits
  `CGES_ASSERT_SAME(a_in_ready, clk, rst, s_axis_tvalid || !s_axis_tvalid, s_axis_tready == (!m_axis_tvalid || m_axis_tready))

  // reset flushes the pipeline
  `CGES_ASSERT_RESET(a_rst_flush, clk, $past(rst), !m_axis_tvalid)

endmodule

bind central_gravity_euler_step_core cges_chk #(.DATA_W(OUT_W)) u_cges_chk (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tuser(m_axis_tuser)
);
